// File: rtl/ise_pkg.sv
package ise_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 32;
  localparam int unsigned DATA_WIDTH_DEF   = 32;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic key_rd;
    logic key_cap;
    logic shift;
    logic insert;
    logic out_init;
    logic out_rd;
    logic out_cap;
    logic out_next;
    logic set_done;
  } ise_cmd_t;

  typedef struct packed {
    logic pos_end;
    logic greater;
    logic hole_low;
    logic out_end;
  } ise_sts_t;

endpackage

// File: rtl/ise_ram.sv
module ise_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ise_datapath.sv
module ise_datapath #(
  parameter int unsigned MAX_ELEMENTS = 32,
  parameter int unsigned DATA_WIDTH   = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ise_pkg::ise_cmd_t            cmd_i,
  output ise_pkg::ise_sts_t            sts_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         last_out_o,
  output logic                         overflow_o
);

  import ise_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] hole_q, hole_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] out_value_q;
  logic          out_last_q, out_ovf_q;

  logic [CW-1:0] hole_m1, hole_m2, pos_p1;
  logic          count_lt;

  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  assign hole_m1  = hole_q - CW'(1);
  assign hole_m2  = hole_q - CW'(2);
  assign pos_p1   = pos_q + CW'(1);
  assign count_lt = count_q < CW'(MAX_ELEMENTS);

  assign sts_o.pos_end  = pos_q >= count_q;
  assign sts_o.greater  = $signed(rdata) > $signed(key_q);
  assign sts_o.hole_low = hole_q == CW'(1);
  assign sts_o.out_end  = pos_p1 == count_q;

  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    re    = 1'b0;
    raddr = pos_q[AW-1:0];
    if (cmd_i.load && count_lt) begin
      we = 1'b1;
    end
    if (cmd_i.shift) begin
      we    = 1'b1;
      waddr = hole_q[AW-1:0];
      wdata = rdata;
      re    = !sts_o.hole_low;
      raddr = hole_m2[AW-1:0];
    end
    if (cmd_i.insert) begin
      we    = 1'b1;
      waddr = hole_q[AW-1:0];
      wdata = key_q;
    end
    if (cmd_i.key_rd || cmd_i.out_rd) begin
      re = 1'b1;
    end
    if (cmd_i.key_cap) begin
      re    = 1'b1;
      raddr = hole_m1[AW-1:0];
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    pos_d     = pos_q;
    hole_d    = hole_q;
    key_d     = key_q;
    if (cmd_i.load) begin
      if (count_lt) begin
        count_d = count_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.sort_init) begin
      pos_d = CW'(1);
    end
    if (cmd_i.key_rd) begin
      hole_d = pos_q;
    end
    if (cmd_i.key_cap) begin
      key_d = rdata;
    end
    if (cmd_i.shift) begin
      hole_d = hole_m1;
    end
    if (cmd_i.insert || cmd_i.out_next) begin
      pos_d = pos_p1;
    end
    if (cmd_i.out_init) begin
      pos_d = '0;
    end
    if (cmd_i.set_done) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      pos_q     <= '0;
      hole_q    <= '0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      pos_q     <= pos_d;
      hole_q    <= hole_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (cmd_i.out_cap) begin
      out_value_q <= rdata;
      out_last_q  <= sts_o.out_end;
      out_ovf_q   <= dropped_q;
    end
  end

  ise_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

// File: rtl/ise_ctrl.sv
module ise_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ise_pkg::ise_cmd_t cmd_o,
  input  ise_pkg::ise_sts_t sts_i
);

  import ise_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_KEYRD = 3'd1;
  localparam logic [2:0] S_KEYWT = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OWT   = 3'd6;
  localparam logic [2:0] S_OHOLD = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o  = state_q != S_LOAD;
  assign out_valid_o = state_q == S_OHOLD;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.sort_init = 1'b1;
            state_d         = S_KEYRD;
          end
        end
      end
      S_KEYRD: begin
        if (sts_i.pos_end) begin
          cmd_o.out_init = 1'b1;
          state_d        = S_ORD;
        end else begin
          cmd_o.key_rd = 1'b1;
          state_d      = S_KEYWT;
        end
      end
      S_KEYWT: begin
        cmd_o.key_cap = 1'b1;
        state_d       = S_CMP;
      end
      S_CMP: begin
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          if (sts_i.hole_low) begin
            state_d = S_INS;
          end
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = S_KEYRD;
        end
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        state_d      = S_KEYRD;
      end
      S_ORD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = S_OWT;
      end
      S_OWT: begin
        cmd_o.out_cap = 1'b1;
        state_d       = S_OHOLD;
      end
      S_OHOLD: begin
        if (!out_stall_i) begin
          if (sts_i.out_end) begin
            cmd_o.set_done = 1'b1;
            state_d        = S_LOAD;
          end else begin
            cmd_o.out_next = 1'b1;
            state_d        = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/insertion_sort_engine_core.sv
// insertion sort engine
// input channel (in_valid_i / in_stall_o, value_i, last_i): one word per element
// of a set; a word with last_i high closes the set. words are taken at one per
// cycle while the set loads. words beyond MAX_ELEMENTS are dropped and the set
// is then flagged with overflow_o on all of its results.
// after the closing word the stored set is sorted ascending (signed compare,
// equal values keep arrival order) in place in a single-port-read RAM:
// each element is read as the key and compared with the entries below it,
// shifting each larger one up a place before the key is inserted.
// output channel (out_valid_o / out_stall_i, sorted_value_o, last_out_o,
// overflow_o): one word per element, last_out_o on the final one. a word is
// read, captured, then shown until it is taken; a stalled word holds steady.
// in_stall_o stays high from the closing word until the final result is taken,
// so the next set cannot load until the current one is sorted and output.
// reset clears the element count and the overflow flag and drops any set in
// progress; the store itself is not cleared and needs no sweep.
module insertion_sort_engine_core #(
  parameter int unsigned MAX_ELEMENTS = ise_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned DATA_WIDTH   = ise_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] sorted_value_o,
  output logic                         last_out_o,
  output logic                         overflow_o
);

  import ise_pkg::*;

  ise_cmd_t cmd;
  ise_sts_t sts;

  ise_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ise_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

`ifndef SYNTHESIS
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("input open while a result is shown");

  a_next_word_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_out_o) |=> (!out_valid_o && in_stall_o))
    else $error("set ended early or word repeated");

  a_reopen_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_out_o) |=> (!in_stall_o && !out_valid_o))
    else $error("input not reopened after final result");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.shift, cmd.insert}))
    else $error("store write conflict");
`endif

endmodule

// File: tb/sv/insertion_sort_engine_core_test.sv
module insertion_sort_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW    = ise_pkg::DATA_WIDTH_DEF;
  localparam int unsigned CAP   = ise_pkg::MAX_ELEMENTS_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef enum int {
    FILL_FULL,
    FILL_NARROW,
    FILL_RISING,
    FILL_FALLING,
    FILL_EDGES
  } fill_mode_e;

  typedef struct {
    logic signed [DW-1:0] value;
    logic                 last;
  } load_word_t;

  typedef struct {
    logic signed [DW-1:0] sval;
    logic                 last_out;
    logic                 ovf;
  } sorted_word_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic signed [DW-1:0] value_i        = '0;
  logic                 last_i         = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic signed [DW-1:0] sorted_value_o;
  logic                 last_out_o;
  logic                 overflow_o;

  load_word_t   load_words[$];
  sorted_word_t sorted_words[$];

  // predictor state: the set being collected
  logic signed [DW-1:0] held_set[$];
  logic                 held_dropped = 1'b0;

  int unsigned words_in     = 0;
  int unsigned words_out    = 0;
  int unsigned sets_done    = 0;
  int unsigned ovf_sets     = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          stuck        = 1'b0;

  insertion_sort_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // store the word, and on the closing word sort the set and queue its results
  function automatic void collect_and_sort(logic signed [DW-1:0] v, logic lst);
    logic signed [DW-1:0] key;
    int                   hole;
    int                   n;
    sorted_word_t         w;
    if (held_set.size() < CAP) held_set.push_back(v);
    else held_dropped = 1'b1;
    if (lst) begin
      n = held_set.size();
      for (int pos = 1; pos < n; pos++) begin
        key  = held_set[pos];
        hole = pos;
        while (hole > 0 && held_set[hole-1] > key) begin
          held_set[hole] = held_set[hole-1];
          hole--;
        end
        held_set[hole] = key;
      end
      for (int k = 0; k < n; k++) begin
        w.sval     = held_set[k];
        w.last_out = (k == n - 1);
        w.ovf      = held_dropped;
        sorted_words.push_back(w);
      end
      sets_done++;
      if (held_dropped) ovf_sets++;
      held_set.delete();
      held_dropped = 1'b0;
    end
  endfunction

  function automatic void queue_word(logic signed [DW-1:0] v, logic lst);
    load_word_t w;
    w.value = v;
    w.last  = lst;
    load_words.push_back(w);
  endfunction

  function automatic int edge_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_set(int n, fill_mode_e mode);
    int vals[$];
    for (int i = 0; i < n; i++) begin
      case (mode)
        FILL_NARROW: vals.push_back(int'($urandom_range(7)) - 4);
        FILL_EDGES:  vals.push_back(edge_value());
        default:     vals.push_back(int'($urandom));
      endcase
    end
    if (mode == FILL_RISING) vals.sort();
    if (mode == FILL_FALLING) vals.rsort();
    for (int i = 0; i < n; i++) queue_word(vals[i], i == n - 1);
  endfunction

  // driver
  always @(posedge clk_i) begin : drive
    load_word_t w;
    bit         calm;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        collect_and_sort(value_i, last_i);
        words_in++;
      end
      calm = (words_in >= 100 && words_in < 170);
      if (!(in_valid_i && in_stall_o)) begin
        if (load_words.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
          w = load_words.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= w.value;
          last_i     <= w.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch
    sorted_word_t want;
    bit           calm;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sorted_words.size() == 0) begin
          $display("%0t: unexpected word value %0d last %0b overflow %0b", $time,
                   sorted_value_o, last_out_o, overflow_o);
          errors++;
        end else begin
          want = sorted_words.pop_front();
          if (sorted_value_o !== want.sval) begin
            $display("%0t: sorted_value expected %0d got %0d", $time, want.sval,
                     sorted_value_o);
            errors++;
          end
          if (last_out_o !== want.last_out) begin
            $display("%0t: last_out expected %0b got %0b", $time, want.last_out,
                     last_out_o);
            errors++;
          end
          if (overflow_o !== want.ovf) begin
            $display("%0t: overflow expected %0b got %0b", $time, want.ovf, overflow_o);
            errors++;
          end
        end
        words_out++;
      end
      calm = (words_out >= 100 && words_out < 170);
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 24);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT)
      stuck <= 1'b1;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int         n;
    int         planned;
    int         pick;
    fill_mode_e mode;

    // directed sets
    queue_word(32'sh8000_0000, 1'b1);
    queue_word(32'sh7fff_ffff, 1'b1);
    queue_word(32'sh7fff_ffff, 1'b0);
    queue_word(32'sh8000_0000, 1'b0);
    queue_word(0, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(1, 1'b1);
    for (int i = 0; i < 6; i++) queue_word(60 - 10 * i, i == 5);
    queue_word(3, 1'b0);
    queue_word(-3, 1'b0);
    queue_word(3, 1'b0);
    queue_word(-3, 1'b0);
    queue_word(3, 1'b1);
    for (int i = 0; i < 4; i++) queue_word(-2 + i, i == 3);

    // full store, closing word dropped, and deeper overflow
    queue_set(CAP, FILL_FULL);
    queue_set(CAP + 1, FILL_FALLING);
    queue_set(CAP + 2, FILL_NARROW);
    planned = 3 * CAP + 3;
    while (planned < 250) begin
      pick = $urandom_range(99);
      if (pick < 70) n = $urandom_range(10, 1);
      else if (pick < 85) n = $urandom_range(CAP - 1, 11);
      else n = $urandom_range(CAP + 8, CAP);
      mode = fill_mode_e'($urandom_range(4));
      if (mode == FILL_EDGES && $urandom_range(1)) mode = FILL_FULL;
      queue_set(n, mode);
      planned += n;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((load_words.size() != 0 || in_valid_i || sorted_words.size() != 0) && !stuck)
      @(posedge clk_i);

    if (stuck) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
    end else begin
      repeat (64) @(posedge clk_i);
      $display("covered %0d sets (%0d with dropped words), %0d words in, %0d sorted out",
               sets_done, ovf_sets, words_in, words_out);
      if (errors == 0 && sorted_words.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("%0d mismatches, %0d results missing", errors, sorted_words.size());
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

endmodule
